// ===== rtl/mmq_pkg.sv =====
package mmq_pkg;

    localparam logic [1:0] MODE_LEARN  = 2'd0;
    localparam logic [1:0] MODE_ENCODE = 2'd1;
    localparam logic [1:0] MODE_DECODE = 2'd2;

    localparam logic [15:0] STEPS    = 16'd65025;
    localparam logic [7:0]  LEVELS   = 8'd255;
    localparam logic [7:0]  CODE_MAX = 8'd254;
    localparam logic [7:0]  CODE_BAD = 8'd255;

    localparam logic [5:0] ENC_STEPS   = 6'd17;
    localparam logic [5:0] DEC_STEPS   = 6'd32;
    localparam logic [5:0] SPLIT_STEPS = 6'd8;

    typedef struct packed {
        logic        start;
        logic [5:0]  steps;
        logic [31:0] rem_init;
        logic [31:0] num_init;
        logic [31:0] divisor;
    } mmq_div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quotient;
        logic [31:0] remainder;
    } mmq_div_sts_t;

endpackage

// ===== rtl/mmq_divider.sv =====
module mmq_divider import mmq_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  mmq_div_req_t req,
    output mmq_div_sts_t sts
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] num_reg, num_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] div_reg, div_next;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        fits;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, num_reg[31]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            rem_next  = req.rem_init;
            num_next  = req.num_init;
            quo_next  = '0;
            div_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[31:0] : trial[31:0];
            quo_next = {quo_reg[30:0], fits};
            num_next = {num_reg[30:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign sts.busy      = busy_reg;
    assign sts.done      = done_reg;
    assign sts.quotient  = quo_reg;
    assign sts.remainder = rem_reg;

    ast_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    ast_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !req.start) |-> (cnt_reg != 6'd0))
        else $error("divider running with zero steps left");

    ast_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");

endmodule

// ===== rtl/minmax_two_level_quantizer_core.sv =====
// Min/max two-level quantizer for signed Q16.16 samples. Mode 0 learns the
// running minimum and maximum (first seeds both), mode 1 encodes a sample into
// a coarse and a fine code of 255 levels each over the learned range, mode 2
// decodes a code pair back to a value; mode 3, a coarse code of 255 on decode and an
// encode sample outside the learned range give error. One transaction is worked at a
// time. Learn, error and zero-range encode transactions pass from acceptance through
// ST_FINISH to the output register. Other encodes and decodes take ST_MUL, then a
// bit-serial divider that retires one quotient bit per cycle (17 bits for the scaled
// offset plus 8 bits for the coarse/fine split on encode, 32 bits on decode). s_ready
// is high only between transactions; a finished result waits in the output register.
module minmax_two_level_quantizer_core import mmq_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic               s_first,
    input  logic signed [31:0] s_sample,
    input  logic [7:0]         s_coarse_in,
    input  logic [7:0]         s_fine_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_coarse_code,
    output logic [7:0]         m_fine_code,
    output logic signed [31:0] m_value,
    output logic               m_error
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MUL    = 5'b00010,
        ST_DIV1   = 5'b00100,
        ST_DIV2   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic signed [31:0] lowest_reg, lowest_next;
    logic signed [31:0] highest_reg, highest_next;
    logic               enc_reg, enc_next;
    logic [31:0]        fa_reg, fa_next;
    logic [15:0]        fb_reg, fb_next;
    logic [7:0]         res_coarse_reg, res_coarse_next;
    logic [7:0]         res_fine_reg, res_fine_next;
    logic [31:0]        res_value_reg, res_value_next;
    logic               res_error_reg, res_error_next;
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_coarse_reg, m_coarse_next;
    logic [7:0]         m_fine_reg, m_fine_next;
    logic [31:0]        m_value_reg, m_value_next;
    logic               m_error_reg, m_error_next;

    logic               accept;
    logic [31:0]        range;
    logic [31:0]        offset;
    logic [15:0]        pair;
    logic [47:0]        prod;
    logic [7:0]         quo8;
    mmq_div_req_t       div_req;
    mmq_div_sts_t       div_sts;

    assign accept = s_valid && s_ready;
    assign range  = 32'(highest_reg - lowest_reg);
    assign offset = 32'(s_sample - lowest_reg);
    assign pair   = ({s_coarse_in, 8'b0} - {8'b0, s_coarse_in}) + {8'b0, s_fine_in};
    assign prod   = {16'b0, fa_reg} * {32'b0, fb_reg};
    assign quo8   = div_sts.quotient[7:0];

    mmq_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .sts     (div_sts)
    );

    // divider launch: scaled offset or decode product, then coarse/fine split
    always_comb begin
        div_req = '0;
        if (state_reg == ST_MUL) begin
            div_req.start = 1'b1;
            if (enc_reg) begin
                div_req.steps    = ENC_STEPS;
                div_req.rem_init = {1'b0, prod[47:17]};
                div_req.num_init = {prod[16:0], 15'b0};
                div_req.divisor  = range;
            end else begin
                div_req.steps    = DEC_STEPS;
                div_req.rem_init = {16'b0, prod[47:32]};
                div_req.num_init = prod[31:0];
                div_req.divisor  = {16'b0, STEPS};
            end
        end else if (state_reg == ST_DIV1 && div_sts.done && enc_reg) begin
            div_req.start    = 1'b1;
            div_req.steps    = SPLIT_STEPS;
            div_req.rem_init = {23'b0, div_sts.quotient[16:8]};
            div_req.num_init = {div_sts.quotient[7:0], 24'b0};
            div_req.divisor  = {24'b0, LEVELS};
        end
    end

    always_comb begin
        state_next      = state_reg;
        lowest_next     = lowest_reg;
        highest_next    = highest_reg;
        enc_next        = enc_reg;
        fa_next         = fa_reg;
        fb_next         = fb_reg;
        res_coarse_next = res_coarse_reg;
        res_fine_next   = res_fine_reg;
        res_value_next  = res_value_reg;
        res_error_next  = res_error_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_coarse_next   = m_coarse_reg;
        m_fine_next     = m_fine_reg;
        m_value_next    = m_value_reg;
        m_error_next    = m_error_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_coarse_next = '0;
                    res_fine_next   = '0;
                    res_value_next  = '0;
                    res_error_next  = 1'b0;
                    state_next      = ST_FINISH;
                    case (s_mode)
                        MODE_LEARN: begin
                            if (s_first) begin
                                lowest_next  = s_sample;
                                highest_next = s_sample;
                            end else begin
                                if (s_sample < lowest_reg) begin
                                    lowest_next = s_sample;
                                end
                                if (s_sample > highest_reg) begin
                                    highest_next = s_sample;
                                end
                            end
                        end
                        MODE_ENCODE: begin
                            if (s_sample < lowest_reg || s_sample > highest_reg) begin
                                res_error_next = 1'b1;
                            end else if (range != 32'd0) begin
                                enc_next   = 1'b1;
                                fa_next    = offset;
                                fb_next    = STEPS;
                                state_next = ST_MUL;
                            end
                        end
                        MODE_DECODE: begin
                            if (s_coarse_in == CODE_BAD) begin
                                res_error_next = 1'b1;
                            end else begin
                                enc_next   = 1'b0;
                                fa_next    = range;
                                fb_next    = pair;
                                state_next = ST_MUL;
                            end
                        end
                        default: begin
                            res_error_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                state_next = ST_DIV1;
            end
            ST_DIV1: begin
                if (div_sts.done) begin
                    if (enc_reg) begin
                        state_next = ST_DIV2;
                    end else begin
                        res_value_next = 32'(lowest_reg) + div_sts.quotient;
                        state_next     = ST_FINISH;
                    end
                end
            end
            ST_DIV2: begin
                if (div_sts.done) begin
                    res_coarse_next = (quo8 == CODE_BAD) ? CODE_MAX : quo8;
                    res_fine_next   = div_sts.remainder[7:0];
                    state_next      = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_coarse_next = res_coarse_reg;
                    m_fine_next   = res_fine_reg;
                    m_value_next  = res_value_reg;
                    m_error_next  = res_error_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            lowest_reg  <= '0;
            highest_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            lowest_reg  <= lowest_next;
            highest_reg <= highest_next;
            m_valid_reg <= m_valid_next;
        end
        enc_reg        <= enc_next;
        fa_reg         <= fa_next;
        fb_reg         <= fb_next;
        res_coarse_reg <= res_coarse_next;
        res_fine_reg   <= res_fine_next;
        res_value_reg  <= res_value_next;
        res_error_reg  <= res_error_next;
        m_coarse_reg   <= m_coarse_next;
        m_fine_reg     <= m_fine_next;
        m_value_reg    <= m_value_next;
        m_error_reg    <= m_error_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_coarse_code = m_coarse_reg;
    assign m_fine_code   = m_fine_reg;
    assign m_value       = m_value_reg;
    assign m_error       = m_error_reg;

    ast_ready_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_sts.busy)
        else $error("ready while the divider is running");

    ast_learn_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_mode == MODE_LEARN) |=> (state_reg == ST_FINISH))
        else $error("learn transaction did not go straight to finish");

    ast_bounds_order: assert property (@(posedge aclk) disable iff (!aresetn)
        lowest_reg <= highest_reg)
        else $error("learned minimum above maximum");

    ast_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error) |->
            (m_coarse_code == 8'd0 && m_fine_code == 8'd0 && m_value == 32'sd0))
        else $error("error result carries nonzero fields");

    ast_coarse_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_coarse_code != CODE_BAD))
        else $error("coarse code out of range");

endmodule

// ===== bench/minmax_two_level_quantizer_core_tb.sv =====
`timescale 1ns / 100ps

module minmax_two_level_quantizer_core_tb;
    import mmq_pkg::*;

    localparam logic [1:0] MODE_INVALID = 2'd3;
    localparam int RESET_CYCLES = 9;
    localparam int MAX_GAP = 10;
    localparam int LONG_HOLD = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS = 800;

    typedef struct packed {
        logic [7:0]         coarse;
        logic [7:0]         fine;
        logic signed [31:0] value;
        logic               error;
    } code_result_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_mode;
    logic               s_first;
    logic signed [31:0] s_sample;
    logic [7:0]         s_coarse_in;
    logic [7:0]         s_fine_in;
    logic               m_valid;
    logic               m_ready;
    logic [7:0]         m_coarse_code;
    logic [7:0]         m_fine_code;
    logic signed [31:0] m_value;
    logic               m_error;

    logic signed [31:0] lo_q;
    logic signed [31:0] hi_q;
    code_result_t       pending_codes[$];
    int                 mismatches = 0;
    int                 results_checked = 0;
    int                 items_sent = 0;
    int                 flagged_errors = 0;
    int                 mode_count[4] = '{0, 0, 0, 0};
    int                 long_hold = 0;
    int                 send_calm = 0;
    int                 recv_calm = 0;
    int                 idle_cycles = 0;

    minmax_two_level_quantizer_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_first       (s_first),
        .s_sample      (s_sample),
        .s_coarse_in   (s_coarse_in),
        .s_fine_in     (s_fine_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_coarse_code (m_coarse_code),
        .m_fine_code   (m_fine_code),
        .m_value       (m_value),
        .m_error       (m_error)
    );

    always #2 aclk = ~aclk;

    function automatic code_result_t quantizer_step(input logic [1:0] mode, input logic first,
                                                    input logic signed [31:0] x,
                                                    input logic [7:0] c_in,
                                                    input logic [7:0] f_in);
        code_result_t res;
        logic [63:0]  range_w;
        logic [63:0]  offset;
        logic [63:0]  scaled;
        logic [63:0]  code_idx;
        res = '0;
        range_w = (hi_q > lo_q) ? 64'(longint'(hi_q) - longint'(lo_q)) : 64'd0;
        case (mode)
            MODE_LEARN: begin
                if (first) begin
                    lo_q = x;
                    hi_q = x;
                end else begin
                    if (x < lo_q) lo_q = x;
                    if (x > hi_q) hi_q = x;
                end
            end
            MODE_ENCODE: begin
                if (x < lo_q || x > hi_q) begin
                    res.error = 1'b1;
                end else if (range_w != 64'd0) begin
                    offset = 64'(longint'(x) - longint'(lo_q));
                    scaled = offset * STEPS / range_w;
                    res.coarse = (scaled / LEVELS > CODE_MAX) ? CODE_MAX : 8'(scaled / LEVELS);
                    res.fine = (scaled % LEVELS > CODE_MAX) ? CODE_MAX : 8'(scaled % LEVELS);
                end
            end
            MODE_DECODE: begin
                if (c_in == CODE_BAD) begin
                    res.error = 1'b1;
                end else begin
                    code_idx = 64'(c_in) * LEVELS + 64'(f_in);
                    offset = code_idx * range_w / STEPS;
                    res.value = lo_q + offset[31:0];
                end
            end
            default: res.error = 1'b1;
        endcase
        return res;
    endfunction

    task automatic send_item(input logic [1:0] mode, input logic first,
                             input logic signed [31:0] x, input logic [7:0] c_in,
                             input logic [7:0] f_in);
        int           gap;
        code_result_t predicted;
        gap = $urandom_range(0, MAX_GAP);
        if (send_calm == 0 && $urandom_range(0, 19) == 0) send_calm = $urandom_range(5, 30);
        if (send_calm != 0) begin
            gap = 0;
            send_calm--;
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_mode      <= mode;
        s_first     <= first;
        s_sample    <= x;
        s_coarse_in <= c_in;
        s_fine_in   <= f_in;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted = quantizer_step(mode, first, x, c_in, f_in);
        pending_codes = {pending_codes, predicted};
        items_sent++;
        mode_count[mode]++;
        if (predicted.error) flagged_errors++;
    endtask

    task automatic test_reset_state();
        send_item(MODE_ENCODE, 1'b0, 32'sd0, 8'd0, 8'd0);
        send_item(MODE_ENCODE, 1'b0, 32'sd1, 8'd0, 8'd0);
        send_item(MODE_DECODE, 1'b0, 32'sd0, 8'd254, 8'd255);
        send_item(MODE_DECODE, 1'b0, 32'sd0, CODE_BAD, 8'd0);
        send_item(MODE_INVALID, 1'b0, 32'sd0, 8'd0, 8'd0);
        // no first mark: compared against the zero reset values
        send_item(MODE_LEARN, 1'b0, 32'sd1000, 8'd0, 8'd0);
    endtask

    task automatic test_full_range_extremes();
        send_item(MODE_LEARN, 1'b1, 32'sh8000_0000, 8'hff, 8'hff);
        send_item(MODE_LEARN, 1'b0, 32'sh7fff_ffff, 8'h00, 8'h00);
        send_item(MODE_ENCODE, 1'b0, 32'sh8000_0000, 8'd0, 8'd0);
        send_item(MODE_ENCODE, 1'b0, 32'sh7fff_ffff, 8'd0, 8'd0);
        send_item(MODE_ENCODE, 1'b0, 32'sh7fff_fffe, 8'd0, 8'd0);
        send_item(MODE_ENCODE, 1'b1, 32'sd0, 8'd0, 8'd0);
        send_item(MODE_DECODE, 1'b0, 32'sd0, 8'd0, 8'd0);
        send_item(MODE_DECODE, 1'b0, 32'sd0, 8'd254, 8'd255);
        send_item(MODE_DECODE, 1'b0, 32'sd0, 8'd254, 8'd254);
        send_item(MODE_DECODE, 1'b1, 32'sh7fff_ffff, 8'd0, 8'd255);
        send_item(MODE_DECODE, 1'b0, 32'sd0, CODE_BAD, 8'd7);
        send_item(MODE_INVALID, 1'b1, 32'sh7fff_ffff, 8'hff, 8'hff);
    endtask

    task automatic test_narrow_range();
        send_item(MODE_LEARN, 1'b1, 32'sd100, 8'd0, 8'd0);
        send_item(MODE_ENCODE, 1'b0, 32'sd99, 8'd0, 8'd0);
        send_item(MODE_ENCODE, 1'b0, 32'sd101, 8'd0, 8'd0);
        send_item(MODE_ENCODE, 1'b0, 32'sd100, 8'd0, 8'd0);
        send_item(MODE_DECODE, 1'b0, 32'sd0, 8'd200, 8'd100);
    endtask

    task automatic test_random_sequences(input int n_items);
        int                 stop_at;
        int                 n_ops;
        int                 pick;
        int                 width;
        logic [31:0]        spread;
        logic signed [31:0] seed;
        logic signed [31:0] x;
        logic [7:0]         c_in;
        longint unsigned    span_u;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise
                send_item(2'($urandom), 1'($urandom), $urandom, 8'($urandom), 8'($urandom));
            end else begin
                width = $urandom_range(0, 32);
                spread = (width == 32) ? 32'hffff_ffff : (32'd1 << width) - 32'd1;
                seed = $urandom;
                send_item(MODE_LEARN, 1'b1, seed, 8'($urandom), 8'($urandom));
                repeat ($urandom_range(0, 5)) begin
                    send_item(MODE_LEARN, 1'b0, seed + ($urandom & spread) - (spread >> 1),
                              8'($urandom), 8'($urandom));
                end
                n_ops = $urandom_range(4, 16);
                repeat (n_ops) begin
                    pick = $urandom_range(0, 99);
                    span_u = longint'(hi_q) - longint'(lo_q);
                    if (pick < 55) begin
                        x = lo_q + 32'({$urandom, $urandom} % (span_u + 1));
                        send_item(MODE_ENCODE, 1'($urandom), x, 8'($urandom), 8'($urandom));
                    end else if (pick < 62) begin
                        x = $urandom_range(0, 1) ? lo_q : hi_q;
                        send_item(MODE_ENCODE, 1'($urandom), x, 8'($urandom), 8'($urandom));
                    end else if (pick < 72) begin
                        case ($urandom_range(0, 2))
                            0: x = lo_q - 32'sd1;
                            1: x = hi_q + 32'sd1;
                            default: x = $urandom;
                        endcase
                        send_item(MODE_ENCODE, 1'($urandom), x, 8'($urandom), 8'($urandom));
                    end else if (pick < 95) begin
                        c_in = ($urandom_range(0, 19) == 0) ? CODE_BAD
                                                            : 8'($urandom_range(0, 254));
                        send_item(MODE_DECODE, 1'($urandom), $urandom, c_in,
                                  8'($urandom_range(0, 255)));
                    end else if (pick < 98) begin
                        send_item(MODE_LEARN, 1'b0, seed + ($urandom & spread) - (spread >> 1),
                                  8'($urandom), 8'($urandom));
                    end else begin
                        send_item(MODE_INVALID, 1'($urandom), $urandom, 8'($urandom),
                                  8'($urandom));
                    end
                end
            end
        end
    endtask

    task automatic test_output_backpressure();
        long_hold = LONG_HOLD;
        send_item(MODE_LEARN, 1'b1, $urandom, 8'd0, 8'd0);
        send_item(MODE_LEARN, 1'b0, $urandom, 8'd0, 8'd0);
        repeat (30) begin
            send_item($urandom_range(0, 1) ? MODE_ENCODE : MODE_DECODE, 1'b0, $urandom,
                      8'($urandom_range(0, 254)), 8'($urandom));
        end
    endtask

    // result side: random stalls, one long hold on request
    initial begin
        int           stall;
        code_result_t want;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (long_hold != 0) begin
                stall = long_hold;
                long_hold = 0;
            end else begin
                stall = $urandom_range(0, MAX_GAP);
                if (recv_calm == 0 && $urandom_range(0, 19) == 0) begin
                    recv_calm = $urandom_range(5, 30);
                end
                if (recv_calm != 0) begin
                    stall = 0;
                    recv_calm--;
                end
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            results_checked++;
            if (pending_codes.size() == 0) begin
                $error("result transaction with nothing pending");
                mismatches++;
            end else begin
                want = pending_codes.pop_front();
                if (m_coarse_code !== want.coarse) begin
                    $error("coarse_code: expected %0d, actual %0d", want.coarse, m_coarse_code);
                    mismatches++;
                end
                if (m_fine_code !== want.fine) begin
                    $error("fine_code: expected %0d, actual %0d", want.fine, m_fine_code);
                    mismatches++;
                end
                if (m_value !== want.value) begin
                    $error("value: expected %0d, actual %0d", want.value, m_value);
                    mismatches++;
                end
                if (m_error !== want.error) begin
                    $error("error: expected %0b, actual %0b", want.error, m_error);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d results pending",
                         idle_cycles, pending_codes.size());
                $display("minmax_two_level_quantizer_core: mismatch");
                $finish;
            end
        end
    end

    initial begin
        lo_q = '0;
        hi_q = '0;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_mode      <= MODE_LEARN;
        s_first     <= 1'b0;
        s_sample    <= '0;
        s_coarse_in <= '0;
        s_fine_in   <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_full_range_extremes();
        test_narrow_range();
        test_random_sequences(RANDOM_ITEMS);
        test_output_backpressure();

        s_valid <= 1'b0;
        while (pending_codes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d transactions: %0d learn, %0d encode, %0d decode, %0d bad mode",
                 items_sent, mode_count[MODE_LEARN], mode_count[MODE_ENCODE],
                 mode_count[MODE_DECODE], mode_count[MODE_INVALID]);
        $display("checked %0d results, %0d with error set, incl. a %0d-cycle output hold",
                 results_checked, flagged_errors, LONG_HOLD);
        if (mismatches == 0) begin
            $display("minmax_two_level_quantizer_core: match");
        end else begin
            $display("minmax_two_level_quantizer_core: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mmq_pkg.sv
rtl/mmq_divider.sv
rtl/minmax_two_level_quantizer_core.sv
bench/minmax_two_level_quantizer_core_tb.sv
